// ----- rtl/sce_pkg.sv -----
`default_nettype none

package sce_pkg;

  // timing constants of the servo
  localparam int unsigned TIME_PER_POSITION = 200;
  localparam int unsigned BASE_WAIT         = 100;
  localparam int unsigned TIMER_BITS        = 24;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned STATE_W  = 2;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W   = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // highest legal position
  localparam logic [VALUE_W-1:0] MAX_POS = VALUE_W'(5);

  // pulse width = floor(period * num / 50000), done as ((x >> 4) / 3125)
  localparam int unsigned NUM_W      = 18;
  localparam int unsigned PROD_W     = PERIOD_W + NUM_W;
  localparam int unsigned PRE_SHIFT  = 4;
  localparam int unsigned DIV_ODD    = 3125;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned Y_W        = 28;
  localparam int unsigned RECIP_W    = 29;
  localparam int unsigned QEST_W     = 17;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SHIFT) / DIV_ODD;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(64'd65536 * 64'd50000);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  // countdown limit
  localparam logic [32:0] TIMER_LIMIT = (33'd1 << TIMER_BITS) - 33'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_WAIT = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [STATE_W-1:0] {
    MODE_READY   = 2'd0,
    MODE_MOVING  = 2'd1,
    MODE_WAITING = 2'd2
  } mode_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY = 2'd2;

  typedef struct packed {
    logic load;
    logic num_en;
    logic mul_en;
    logic div_en;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_move;
  } dp_status_t;

  // saturate a countdown value to the timer width
  function automatic logic [TIMER_BITS-1:0] clamp_timer(input logic [31:0] v);
    logic [TIMER_BITS-1:0] r;
    if ({1'b0, v} > TIMER_LIMIT) begin
      r = '1;
    end else begin
      r = v[TIMER_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sce_datapath.sv -----
`default_nettype none

module sce_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sce_pkg::dp_cmd_t               cmd_i,
  output sce_pkg::dp_status_t                 status_o,
  input  wire logic [sce_pkg::OP_W-1:0]       operation_i,
  input  wire logic [sce_pkg::VALUE_W-1:0]    value_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [sce_pkg::STATE_W-1:0]         servo_state_o,
  output logic [sce_pkg::POS_W-1:0]           position_o,
  output logic [sce_pkg::WIDTH_W-1:0]         pulse_width_o,
  output logic                                pulse_updated_o
);
  import sce_pkg::*;

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   max_duty_q, min_duty_q;

  // latched command
  op_e                op_q;
  logic [VALUE_W-1:0] val_q;

  // pulse width pipeline
  logic [POS_W-1:0]        pos_new;
  logic signed [DUTY_W:0]  duty_diff;
  logic signed [18:0]      pos_term;
  logic signed [18:0]      num_s;
  logic [NUM_W-1:0]        num_d, num_q;
  logic [PROD_W-1:0]       x_d, x_q;
  logic [Y_W-1:0]          y_d, y_q;
  logic [Y_W+RECIP_W-1:0]  yr;
  logic [QEST_W-1:0]       qe_d, qe_q;
  logic                    sat_d, sat_q;
  logic [Y_W-1:0]          rem;
  logic [QEST_W-1:0]       q_fix;

  // servo state
  mode_e                 mode_q, mode_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic [WIDTH_W-1:0]    width_q, width_d;
  logic                  upd_d;
  logic [VALUE_W-1:0]    travel;

  // result registers
  logic [STATE_W-1:0] state_out_q;
  logic [POS_W-1:0]   pos_out_q;
  logic [WIDTH_W-1:0] width_out_q;
  logic               upd_out_q;

  assign status_o.in_is_move = (op_e'(operation_i) == OP_MOVE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_W'(20000);
      max_duty_q <= DUTY_W'(1000);
      min_duty_q <= DUTY_W'(500);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PERIOD:   period_q   <= cfg_data_i[PERIOD_W-1:0];
        CFG_MAX_DUTY: max_duty_q <= cfg_data_i[DUTY_W-1:0];
        CFG_MIN_DUTY: min_duty_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // duty numerator: 5*min + (max-min)*pos, clipped at zero
  always_comb begin
    pos_new   = (val_q <= MAX_POS) ? val_q[POS_W-1:0] : '0;
    duty_diff = signed'({1'b0, max_duty_q}) - signed'({1'b0, min_duty_q});
    pos_term  = 19'(duty_diff) * 19'(signed'({1'b0, pos_new}));
    num_s     = signed'(19'({min_duty_q, 2'b00}) + 19'(min_duty_q)) + pos_term;
    num_d     = (num_s <= 0) ? '0 : num_s[NUM_W-1:0];
  end

  // period times numerator
  assign x_d = PROD_W'(period_q) * PROD_W'(num_q);

  // reciprocal estimate of the quotient, low by at most one
  always_comb begin
    sat_d = (x_q >= SAT_LIMIT);
    y_d   = x_q[PRE_SHIFT +: Y_W];
    yr    = (Y_W+RECIP_W)'(y_d) * (Y_W+RECIP_W)'(RECIP);
    qe_d  = yr[RECIP_SHIFT +: QEST_W];
  end

  // quotient correction
  always_comb begin
    rem   = y_q - Y_W'(Y_W'(qe_q) * Y_W'(DIV_ODD));
    q_fix = (rem >= Y_W'(DIV_ODD)) ? qe_q + QEST_W'(1) : qe_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      val_q <= value_i;
    end
    if (cmd_i.num_en) begin
      num_q <= num_d;
    end
    if (cmd_i.mul_en) begin
      x_q <= x_d;
    end
    if (cmd_i.div_en) begin
      y_q   <= y_d;
      qe_q  <= qe_d;
      sat_q <= sat_d;
    end
  end

  // next servo state on commit
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    ticks_d = ticks_q;
    width_d = width_q;
    upd_d   = 1'b0;
    travel  = (val_q > VALUE_W'(pos_q)) ? val_q - VALUE_W'(pos_q) : VALUE_W'(pos_q) - val_q;
    case (op_q)
      OP_TICK: begin
        if (mode_q != MODE_READY) begin
          if (ticks_q != '0) begin
            ticks_d = ticks_q - TIMER_BITS'(1);
          end
          if (ticks_d == '0) begin
            mode_d = MODE_READY;
          end
        end
      end
      OP_MOVE: begin
        mode_d  = MODE_MOVING;
        pos_d   = pos_new;
        width_d = sat_q ? WIDTH_MAX : q_fix[WIDTH_W-1:0];
        upd_d   = 1'b1;
        ticks_d = clamp_timer(32'(TIME_PER_POSITION) * 32'(travel));
      end
      OP_WAIT: begin
        mode_d  = MODE_WAITING;
        ticks_d = clamp_timer(32'(BASE_WAIT) * 32'(val_q));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_READY;
      pos_q   <= '0;
      ticks_q <= '0;
      width_q <= '0;
    end else if (cmd_i.commit) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      ticks_q <= ticks_d;
      width_q <= width_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      state_out_q <= mode_d;
      pos_out_q   <= pos_d;
      width_out_q <= width_d;
      upd_out_q   <= upd_d;
    end
  end

  assign servo_state_o   = state_out_q;
  assign position_o      = pos_out_q;
  assign pulse_width_o   = width_out_q;
  assign pulse_updated_o = upd_out_q;

endmodule

`default_nettype wire

// ----- rtl/sce_ctrl.sv -----
`default_nettype none

module sce_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire sce_pkg::dp_status_t status_i,
  output sce_pkg::dp_cmd_t         cmd_o
);
  import sce_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_NUM    = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // sequencer
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.load    = in_xfer;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = status_i.in_is_move ? S_NUM : S_COMMIT;
        end
      end
      S_NUM: begin
        cmd_o.num_en = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a transfer in leaves the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // a result is never written over one still waiting
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // commit presents a result on the next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not shown");

  // the width pipeline runs its steps in order
  a_num_then_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NUM) |=> (state_q == S_MUL) ##1 (state_q == S_DIV))
    else $error("pulse width steps out of order");

endmodule

`default_nettype wire

// ----- rtl/servo_command_executor.sv -----
`default_nettype none

// servo command executor
// input channel: operation_i (tick, move, wait) and value_i, transfer on
// in_valid_i & in_ready_o; one result per item on the output channel:
// servo_state_o, position_o, pulse_width_o, pulse_updated_o, transfer on
// out_valid_o & out_ready_i.
// configuration channel: cfg_index_i selects period (0), max duty (1) or
// min duty (2), cfg_data_i carries the value; cfg_ready_o is always high,
// writes to index 3 are dropped. write only while no item is in flight.
// a tick or wait goes from its transfer straight to the commit step; a move
// first runs the pulse width datapath (duty numerator, period multiply,
// reciprocal multiply, remainder correction). one item is worked on at a
// time: the next is taken only after the last one has committed.
// the result sits in an output register, so the block takes the next item
// while a result waits; when the receiver stalls, the following item is
// held at its final step until the output register frees up.
// reset: servo ready at position 0, pulse width 0, period 20000,
// max duty 1000, min duty 500, no result pending.
module servo_command_executor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sce_pkg::OP_W-1:0]       operation_i,
  input  wire logic [sce_pkg::VALUE_W-1:0]    value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sce_pkg::STATE_W-1:0]         servo_state_o,
  output logic [sce_pkg::POS_W-1:0]           position_o,
  output logic [sce_pkg::WIDTH_W-1:0]         pulse_width_o,
  output logic                                pulse_updated_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sce_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sce_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // control
  sce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  sce_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .servo_state_o   (servo_state_o),
    .position_o      (position_o),
    .pulse_width_o   (pulse_width_o),
    .pulse_updated_o (pulse_updated_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_servo_command_executor.sv -----
`timescale 1ns / 100ps

module tb_servo_command_executor;
  import sce_pkg::*;

  // index that maps to no register, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    mode_e               state;
    logic [POS_W-1:0]    pos;
    logic [WIDTH_W-1:0]  width;
    logic                updated;
  } servo_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  op_e                   operation_i = OP_TICK;
  logic [VALUE_W-1:0]    value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATE_W-1:0]    servo_state_o;
  logic [POS_W-1:0]      position_o;
  logic [WIDTH_W-1:0]    pulse_width_o;
  logic                  pulse_updated_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow copy of the servo state and its registers
  logic [PERIOD_W-1:0]   period_q;
  logic [DUTY_W-1:0]     max_duty_q;
  logic [DUTY_W-1:0]     min_duty_q;
  mode_e                 mode_q;
  logic [POS_W-1:0]      pos_q;
  logic [TIMER_BITS-1:0] ticks_q;
  logic [WIDTH_W-1:0]    width_q;

  servo_report_t pending_reports[$];
  int  fail_count = 0;
  bit  idle_on = 1'b1;
  int  stall_left = 0;

  servo_command_executor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .servo_state_o   (servo_state_o),
    .position_o      (position_o),
    .pulse_width_o   (pulse_width_o),
    .pulse_updated_o (pulse_updated_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // pulse width for a position under the current duty setup
  function automatic logic [WIDTH_W-1:0] width_for(logic [POS_W-1:0] pos);
    longint num;
    longint w;
    num = 5 * longint'(min_duty_q)
        + (longint'(max_duty_q) - longint'(min_duty_q)) * longint'(pos);
    if (num <= 0) return '0;
    w = longint'(period_q) * num / 50000;
    return (w > 65535) ? WIDTH_MAX : w[WIDTH_W-1:0];
  endfunction

  // countdown load, saturated to the timer width
  function automatic logic [TIMER_BITS-1:0] countdown_load(longint v);
    longint lim;
    lim = (longint'(1) << TIMER_BITS) - 1;
    return (v > lim) ? '1 : v[TIMER_BITS-1:0];
  endfunction

  // advance the shadow state by one command and report the outcome
  function automatic servo_report_t step_servo(op_e op, logic [VALUE_W-1:0] val);
    servo_report_t r;
    longint v;
    longint p;
    logic upd;
    upd = 1'b0;
    v = longint'(val);
    p = longint'(pos_q);
    case (op)
      OP_TICK: begin
        if (mode_q != MODE_READY) begin
          if (ticks_q != 0) ticks_q = ticks_q - 1'b1;
          if (ticks_q == 0) mode_q = MODE_READY;
        end
      end
      OP_MOVE: begin
        pos_q = (val <= MAX_POS) ? val[POS_W-1:0] : '0;
        mode_q = MODE_MOVING;
        width_q = width_for(pos_q);
        upd = 1'b1;
        ticks_q = countdown_load(longint'(TIME_PER_POSITION) * ((v > p) ? v - p : p - v));
      end
      OP_WAIT: begin
        mode_q = MODE_WAITING;
        ticks_q = countdown_load(v * longint'(BASE_WAIT));
      end
      default: ;
    endcase
    r.state = mode_q;
    r.pos = pos_q;
    r.width = width_q;
    r.updated = upd;
    return r;
  endfunction

  // receiver stalls in bursts; a new burst starts only while idle_on is set
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result transfer with the oldest pending report
  always @(posedge clk_i) begin : check_results
    servo_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("result with no command pending: state %0d pos %0d width %0d upd %0d",
               servo_state_o, position_o, pulse_width_o, pulse_updated_o);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (servo_state_o !== want.state) begin
          $error("servo_state: expected %0d, got %0d", want.state, servo_state_o);
          fail_count++;
        end
        if (position_o !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position_o);
          fail_count++;
        end
        if (pulse_width_o !== want.width) begin
          $error("pulse_width: expected %0d, got %0d", want.width, pulse_width_o);
          fail_count++;
        end
        if (pulse_updated_o !== want.updated) begin
          $error("pulse_updated: expected %0d, got %0d", want.updated, pulse_updated_o);
          fail_count++;
        end
      end
    end
  end

  // one command transfer; valid stays high for the next call
  task automatic send_cmd(op_e op, logic [VALUE_W-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_reports.push_back(step_servo(op, val));
  endtask

  // stop commands and let every pending result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // one register transfer; valid is dropped by the caller
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PERIOD:   period_q = data;
      CFG_MAX_DUTY: max_duty_q = data[DUTY_W-1:0];
      CFG_MIN_DUTY: min_duty_q = data[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // new duty setup once the block is idle, plus a dropped write
  task automatic load_duty_setup(logic [CFG_DATA_W-1:0] period,
                                 logic [CFG_DATA_W-1:0] max_d,
                                 logic [CFG_DATA_W-1:0] min_d);
    drain_results();
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_MAX_DUTY, max_d);
    write_reg(CFG_MIN_DUTY, min_d);
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // move to every position, then off the end of the range, then one tick
  task automatic sweep_positions();
    for (int p = 0; p <= 5; p++) send_cmd(OP_MOVE, VALUE_W'(p));
    send_cmd(OP_MOVE, VALUE_W'($urandom_range(6, 255)));
    send_cmd(OP_TICK, VALUE_W'($urandom));
  endtask

  // mostly well-formed command and countdown sequences, some noise
  task automatic random_commands(int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (mode_q != MODE_READY && ticks_q <= 400 && r < 30) begin
        // run the countdown out and one tick past it
        while (mode_q != MODE_READY) begin
          send_cmd(OP_TICK, VALUE_W'($urandom));
          sent++;
        end
        send_cmd(OP_TICK, VALUE_W'($urandom));
      end else if (r < 45) begin
        send_cmd(OP_MOVE, ($urandom_range(0, 9) == 0) ? VALUE_W'($urandom_range(6, 255))
                                                       : VALUE_W'($urandom_range(0, 5)));
      end else if (r < 60) begin
        send_cmd(OP_WAIT, ($urandom_range(0, 4) == 0) ? VALUE_W'($urandom)
                                                       : VALUE_W'($urandom_range(0, 3)));
      end else if (r < 65) begin
        send_cmd(OP_NONE, VALUE_W'($urandom));
      end else begin
        send_cmd(OP_TICK, VALUE_W'($urandom));
      end
      sent++;
    end
  endtask

  // reset defaults, field extremes and command corner cases
  task automatic test_directed();
    send_cmd(OP_TICK, 8'hFF);
    send_cmd(OP_NONE, 8'hFF);
    send_cmd(OP_MOVE, 8'd5);
    send_cmd(OP_MOVE, 8'd5);
    send_cmd(OP_TICK, 8'h00);
    send_cmd(OP_TICK, 8'hAA);
    send_cmd(OP_MOVE, 8'd200);
    send_cmd(OP_MOVE, 8'd255);
    send_cmd(OP_TICK, 8'h55);
    send_cmd(OP_WAIT, 8'd0);
    send_cmd(OP_TICK, 8'h0F);
    send_cmd(OP_WAIT, 8'd255);
    send_cmd(OP_MOVE, 8'd3);
    send_cmd(OP_NONE, 8'hAA);
    send_cmd(OP_NONE, 8'h55);
    send_cmd(OP_WAIT, 8'd1);
    send_cmd(OP_MOVE, 8'd0);
    send_cmd(OP_MOVE, 8'd6);
    send_cmd(OP_TICK, 8'hF0);
  endtask

  // zero, saturating and inverted duty setups across all positions
  task automatic test_duty_extremes();
    load_duty_setup(16'h0000, 16'h0000, 16'h0000);
    sweep_positions();
    load_duty_setup(16'hFFFF, 16'hFFFF, 16'd10000);
    sweep_positions();
    load_duty_setup(16'hFFFF, 16'd10000, 16'd10000);
    sweep_positions();
    load_duty_setup(16'd20000, 16'd0, 16'd10000);
    sweep_positions();
    load_duty_setup(16'd50000, 16'd10000, 16'hFFFF);
    sweep_positions();
  endtask

  // random traffic over several random duty setups
  task automatic test_random_traffic();
    load_duty_setup(16'd20000, 16'd1000, 16'd500);
    random_commands(110);
    for (int ph = 0; ph < 4; ph++) begin
      load_duty_setup(CFG_DATA_W'($urandom),
                      ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                  : CFG_DATA_W'($urandom_range(0, 10000)),
                      ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                  : CFG_DATA_W'($urandom_range(0, 10000)));
      idle_on = (ph != 1);
      random_commands(110);
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    load_duty_setup(16'hFFFF, 16'd10000, 16'd0);
    idle_on = 1'b0;
    random_commands(200);
  endtask

  initial begin
    period_q = 16'd20000;
    max_duty_q = 14'd1000;
    min_duty_q = 14'd500;
    mode_q = MODE_READY;
    pos_q = '0;
    ticks_q = '0;
    width_q = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_duty_extremes();
    test_random_traffic();
    test_full_rate();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run time limit
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sce_pkg.sv
rtl/sce_datapath.sv
rtl/sce_ctrl.sv
rtl/servo_command_executor.sv
tb/tb_servo_command_executor.sv
